@@ design/mku_pkg.sv @@
// ----------------------------------------------------------------------------
// mku_pkg
// Shared types, microcode word layout and the ITU Morse pattern table for the
// keying unit encoder.
// ----------------------------------------------------------------------------
package mku_pkg;

    // pattern storage: one bit per element, first element in the msb, 1 = dash
    localparam int PAT_W = 6;
    localparam int CNT_W = 3;
    localparam int REP_W = 3;

    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // microcode addresses
    typedef logic [2:0] upc_t;
    localparam upc_t UPC_DISPATCH = 3'd0;
    localparam upc_t UPC_SPACE    = 3'd1;
    localparam upc_t UPC_BAD      = 3'd2;
    localparam upc_t UPC_LGAP     = 3'd3;
    localparam upc_t UPC_MARK     = 3'd4;
    localparam upc_t UPC_SPC      = 3'd5;
    localparam upc_t UPC_TGAP     = 3'd6;

    // how the step counter leaves a step
    typedef enum logic [1:0] {
        COND_DISPATCH = 2'd0,
        COND_NEXT     = 2'd1,
        COND_LOOP     = 2'd2
    } cond_t;

    // where the unit count of a step comes from
    typedef enum logic {
        LEN_CONST = 1'b0,
        LEN_ELEM  = 1'b1
    } len_sel_t;

    typedef struct packed {
        logic             wait_in;
        logic             emit;
        logic             key;
        logic             bad;
        len_sel_t         len_sel;
        logic [REP_W-1:0] len;
        logic             shift_pat;
        logic             dec_cnt;
        cond_t            cond;
        upc_t             target;
    } ctrl_t;

    // datapath status towards the sequencer
    typedef struct packed {
        logic start;
        upc_t disp_addr;
        logic unit_go;
        logic final_unit;
        logic more_elem;
        logic eom;
    } stat_t;

    typedef struct packed {
        logic             known;
        logic [CNT_W-1:0] len;
        logic [PAT_W-1:0] bits;
    } pat_entry_t;

    // ITU code lookup
    function automatic pat_entry_t morse_lookup(input logic [7:0] code);
        pat_entry_t e;
        e = '{known: 1'b1, len: 3'd0, bits: 6'b000000};
        unique case (code)
            8'h41: begin e.len = 3'd2; e.bits = 6'b010000; end // A
            8'h42: begin e.len = 3'd4; e.bits = 6'b100000; end // B
            8'h43: begin e.len = 3'd4; e.bits = 6'b101000; end // C
            8'h44: begin e.len = 3'd3; e.bits = 6'b100000; end // D
            8'h45: begin e.len = 3'd1; e.bits = 6'b000000; end // E
            8'h46: begin e.len = 3'd4; e.bits = 6'b001000; end // F
            8'h47: begin e.len = 3'd3; e.bits = 6'b110000; end // G
            8'h48: begin e.len = 3'd4; e.bits = 6'b000000; end // H
            8'h49: begin e.len = 3'd2; e.bits = 6'b000000; end // I
            8'h4A: begin e.len = 3'd4; e.bits = 6'b011100; end // J
            8'h4B: begin e.len = 3'd3; e.bits = 6'b101000; end // K
            8'h4C: begin e.len = 3'd4; e.bits = 6'b010000; end // L
            8'h4D: begin e.len = 3'd2; e.bits = 6'b110000; end // M
            8'h4E: begin e.len = 3'd2; e.bits = 6'b100000; end // N
            8'h4F: begin e.len = 3'd3; e.bits = 6'b111000; end // O
            8'h50: begin e.len = 3'd4; e.bits = 6'b011000; end // P
            8'h51: begin e.len = 3'd4; e.bits = 6'b110100; end // Q
            8'h52: begin e.len = 3'd3; e.bits = 6'b010000; end // R
            8'h53: begin e.len = 3'd3; e.bits = 6'b000000; end // S
            8'h54: begin e.len = 3'd1; e.bits = 6'b100000; end // T
            8'h55: begin e.len = 3'd3; e.bits = 6'b001000; end // U
            8'h56: begin e.len = 3'd4; e.bits = 6'b000100; end // V
            8'h57: begin e.len = 3'd3; e.bits = 6'b011000; end // W
            8'h58: begin e.len = 3'd4; e.bits = 6'b100100; end // X
            8'h59: begin e.len = 3'd4; e.bits = 6'b101100; end // Y
            8'h5A: begin e.len = 3'd4; e.bits = 6'b110000; end // Z
            8'h30: begin e.len = 3'd5; e.bits = 6'b111110; end // 0
            8'h31: begin e.len = 3'd5; e.bits = 6'b011110; end // 1
            8'h32: begin e.len = 3'd5; e.bits = 6'b001110; end // 2
            8'h33: begin e.len = 3'd5; e.bits = 6'b000110; end // 3
            8'h34: begin e.len = 3'd5; e.bits = 6'b000010; end // 4
            8'h35: begin e.len = 3'd5; e.bits = 6'b000000; end // 5
            8'h36: begin e.len = 3'd5; e.bits = 6'b100000; end // 6
            8'h37: begin e.len = 3'd5; e.bits = 6'b110000; end // 7
            8'h38: begin e.len = 3'd5; e.bits = 6'b111000; end // 8
            8'h39: begin e.len = 3'd5; e.bits = 6'b111100; end // 9
            8'h2E: begin e.len = 3'd6; e.bits = 6'b010101; end // full stop
            8'h2C: begin e.len = 3'd6; e.bits = 6'b110011; end // comma
            8'h3A: begin e.len = 3'd6; e.bits = 6'b111000; end // colon
            8'h3F: begin e.len = 3'd6; e.bits = 6'b001100; end // question mark
            8'h27: begin e.len = 3'd6; e.bits = 6'b011110; end // apostrophe
            8'h2D: begin e.len = 3'd6; e.bits = 6'b100001; end // hyphen
            8'h2F: begin e.len = 3'd5; e.bits = 6'b100100; end // slash
            8'h28: begin e.len = 3'd5; e.bits = 6'b101100; end // open bracket
            8'h29: begin e.len = 3'd6; e.bits = 6'b101101; end // close bracket
            8'h22: begin e.len = 3'd6; e.bits = 6'b010010; end // quote
            8'h3D: begin e.len = 3'd5; e.bits = 6'b100010; end // equals
            8'h2B: begin e.len = 3'd5; e.bits = 6'b010100; end // plus
            8'h40: begin e.len = 3'd6; e.bits = 6'b011010; end // at sign
            default: e.known = 1'b0;
        endcase
        return e;
    endfunction

endpackage

@@ design/mku_ucode_rom.sv @@
// ----------------------------------------------------------------------------
// mku_ucode_rom
// Read-only control store: one control word per sequencer step.
// ----------------------------------------------------------------------------
module mku_ucode_rom
    import mku_pkg::*;
(
    input  upc_t  upc,
    output ctrl_t ctrl
);

    // program: dispatch, space run, bad flag, letter gap, mark, element
    // space (loops back to mark), trailing gap
    always_comb
    begin
        ctrl         = '0;
        ctrl.len_sel = LEN_CONST;
        ctrl.cond    = COND_DISPATCH;
        ctrl.target  = UPC_DISPATCH;
        unique case (upc)
            UPC_DISPATCH:
            begin
                ctrl.wait_in = 1'b1;
            end
            UPC_SPACE:
            begin
                ctrl.emit = 1'b1;
                ctrl.len  = 3'd6;
                ctrl.cond = COND_NEXT;
            end
            UPC_BAD:
            begin
                ctrl.emit = 1'b1;
                ctrl.bad  = 1'b1;
                ctrl.len  = 3'd1;
                ctrl.cond = COND_NEXT;
            end
            UPC_LGAP:
            begin
                ctrl.emit   = 1'b1;
                ctrl.len    = 3'd2;
                ctrl.cond   = COND_NEXT;
                ctrl.target = UPC_MARK;
            end
            UPC_MARK:
            begin
                ctrl.emit      = 1'b1;
                ctrl.key       = 1'b1;
                ctrl.len_sel   = LEN_ELEM;
                ctrl.shift_pat = 1'b1;
                ctrl.cond      = COND_NEXT;
                ctrl.target    = UPC_SPC;
            end
            UPC_SPC:
            begin
                ctrl.emit    = 1'b1;
                ctrl.len     = 3'd1;
                ctrl.dec_cnt = 1'b1;
                ctrl.cond    = COND_LOOP;
                ctrl.target  = UPC_MARK;
            end
            UPC_TGAP:
            begin
                ctrl.emit = 1'b1;
                ctrl.len  = 3'd2;
                ctrl.cond = COND_NEXT;
            end
            default:
            begin
                ctrl.wait_in = 1'b1;
            end
        endcase
    end

endmodule

@@ design/mku_sequencer.sv @@
// ----------------------------------------------------------------------------
// mku_sequencer
// Step counter with conditional jumps and the character dispatch branch.
// ----------------------------------------------------------------------------
module mku_sequencer
    import mku_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  ctrl_t ctrl,
    input  stat_t stat,
    output upc_t  upc,
    output upc_t  exit_addr
);

    upc_t upc_reg;
    upc_t upc_next;

    // address taken once the current step has issued its final unit
    always_comb
    begin
        unique case (ctrl.cond)
            COND_NEXT:
                exit_addr = ctrl.target;
            COND_LOOP:
            begin
                if (stat.more_elem)
                    exit_addr = ctrl.target;
                else if (stat.eom)
                    exit_addr = upc_reg + 3'd1;
                else
                    exit_addr = UPC_DISPATCH;
            end
            default:
                exit_addr = UPC_DISPATCH;
        endcase
    end

    // step counter update
    always_comb
    begin
        upc_next = upc_reg;
        if (ctrl.wait_in)
        begin
            if (stat.start)
                upc_next = stat.disp_addr;
        end
        else if (stat.unit_go && stat.final_unit)
        begin
            upc_next = exit_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UPC_DISPATCH;
        else
            upc_reg <= upc_next;
    end

    assign upc = upc_reg;

endmodule

@@ design/mku_datapath.sv @@
// ----------------------------------------------------------------------------
// mku_datapath
// Character decode, element pattern shifter, unit counters, letter-gap flag
// and the output register.
// ----------------------------------------------------------------------------
module mku_datapath
    import mku_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  ctrl_t      ctrl,
    input  upc_t       exit_addr,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       key_on,
    output logic       bad_char,
    output logic       last_unit,
    output stat_t      stat
);

    logic [PAT_W-1:0] pat_reg;
    logic [PAT_W-1:0] pat_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [REP_W-1:0] rep_reg;
    logic [REP_W-1:0] rep_next;
    logic             gap_reg;
    logic             gap_next;
    logic             eom_reg;
    logic             eom_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             key_reg;
    logic             bad_reg;
    logic             last_reg;

    pat_entry_t       entry;
    logic             is_space;
    logic             start;
    logic             unit_go;
    logic             final_unit;
    logic [REP_W-1:0] unit_len;
    upc_t             disp_addr;

    // decode of the offered character
    assign entry    = morse_lookup(char_code);
    assign is_space = (char_code == CHAR_SPACE);

    always_comb
    begin
        if (is_space)
            disp_addr = UPC_SPACE;
        else if (!entry.known)
            disp_addr = UPC_BAD;
        else if (gap_reg)
            disp_addr = UPC_LGAP;
        else
            disp_addr = UPC_MARK;
    end

    // handshake and unit issue
    assign in_ready = ctrl.wait_in;
    assign start    = in_valid && ctrl.wait_in;
    assign unit_go  = ctrl.emit && (!out_valid_reg || out_ready);

    // units in the current step: dash is three on, dot one on
    always_comb
    begin
        unique case (ctrl.len_sel)
            LEN_ELEM: unit_len = pat_reg[PAT_W-1] ? 3'd3 : 3'd1;
            default:  unit_len = ctrl.len;
        endcase
    end

    assign final_unit = (rep_reg == unit_len - 3'd1);

    // working registers
    always_comb
    begin
        pat_next = pat_reg;
        cnt_next = cnt_reg;
        rep_next = rep_reg;
        gap_next = gap_reg;
        eom_next = eom_reg;
        if (start)
        begin
            pat_next = entry.bits;
            cnt_next = entry.len;
            rep_next = '0;
            eom_next = end_of_message;
            if (is_space)
                gap_next = 1'b0;
            else if (!entry.known)
                gap_next = gap_reg && !end_of_message;
            else
                gap_next = !end_of_message;
        end
        else if (unit_go)
        begin
            if (final_unit)
            begin
                rep_next = '0;
                if (ctrl.shift_pat)
                    pat_next = {pat_reg[PAT_W-2:0], 1'b0};
                if (ctrl.dec_cnt)
                    cnt_next = cnt_reg - 3'd1;
            end
            else
            begin
                rep_next = rep_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            cnt_reg <= '0;
            rep_reg <= '0;
            gap_reg <= 1'b0;
            eom_reg <= 1'b0;
        end
        else
        begin
            pat_reg <= pat_next;
            cnt_reg <= cnt_next;
            rep_reg <= rep_next;
            gap_reg <= gap_next;
            eom_reg <= eom_next;
        end
    end

    // output register: one unit held until its transfer
    always_comb
    begin
        if (unit_go)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (unit_go)
        begin
            key_reg  <= ctrl.key;
            bad_reg  <= ctrl.bad;
            last_reg <= final_unit && (exit_addr == UPC_DISPATCH);
        end
    end

    assign out_valid = out_valid_reg;
    assign key_on    = key_reg;
    assign bad_char  = bad_reg;
    assign last_unit = last_reg;

    // status to the sequencer
    assign stat.start      = start;
    assign stat.disp_addr  = disp_addr;
    assign stat.unit_go    = unit_go;
    assign stat.final_unit = final_unit;
    assign stat.more_elem  = (cnt_reg > 3'd1);
    assign stat.eom        = eom_reg;

endmodule

@@ design/morse_keying_unit_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// morse_keying_unit_encoder_unit
// Morse keying unit encoder: one ASCII character in, one on/off keying unit
// out per transfer.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid/in_ready): char_code and end_of_message. A
//   character is taken only while the sequencer sits at its dispatch step.
//   Output channel (out_valid/out_ready): one keying unit per transfer with
//   key_on, bad_char and last_unit; last_unit marks the final unit of the
//   character. A dot is on,off and a dash on,on,on,off; a two-unit letter gap
//   is sent ahead of the next known character, a space gives six off
//   units, end_of_message flushes the owed gap, an unknown code gives one
//   flagged off unit.
//   Timing: a character giving N units (1 to 24) passes one dispatch step,
//   then one unit per cycle while the output does not stall, the microcoded
//   sequencer issuing one unit each unstalled step cycle. The first unit is
//   registered in the first unstalled step cycle and is visible in the cycle after it.
//   Stall: the output register holds one unit; while the receiver holds
//   out_ready low the sequencer waits and loses nothing.
//   Reset: asynchronous, clears the step counter, the output valid flag and
//   the owed letter gap.
// ----------------------------------------------------------------------------
module morse_keying_unit_encoder_unit
    import mku_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_code,
    input  logic       end_of_message,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       key_on,
    output logic       bad_char,
    output logic       last_unit
);

    upc_t  upc;
    upc_t  exit_addr;
    ctrl_t ctrl;
    stat_t stat;

    // control store
    mku_ucode_rom u_rom (
        .upc  (upc),
        .ctrl (ctrl)
    );

    // step counter
    mku_sequencer u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .upc       (upc),
        .exit_addr (exit_addr)
    );

    // datapath
    mku_datapath u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (ctrl),
        .exit_addr      (exit_addr),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_on         (key_on),
        .bad_char       (bad_char),
        .last_unit      (last_unit),
        .stat           (stat)
    );

    // every character produces at least one unit, so the block is busy after
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken again straight after a transfer");

    // a flagged unit is always the single off unit of its character
    a_bad_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && bad_char) |-> (last_unit && !key_on))
        else $error("bad character unit not a lone off unit");

    // a character always finishes on an off unit
    a_last_is_off: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && key_on) |-> !last_unit)
        else $error("character ended on an on unit");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Morse keying unit encoder. It feeds directed
// and random characters over the input channel, predicts the on/off keying
// units for each accepted character and checks every output transfer in
// order, with random idling on both channels.
// ----------------------------------------------------------------------------

// one keying unit as seen on the output channel
typedef struct packed {
    logic key_on;
    logic bad_char;
    logic last_unit;
} keying_unit_t;

class keying_scoreboard;
    keying_unit_t units_due[$];
    logic         gap_owed = 1'b0;
    int           errors;

    // ITU element string for a character, empty when it has no code
    function string morse_pattern(logic [7:0] code);
        case (code)
            "A": return ".-";     "B": return "-...";   "C": return "-.-.";
            "D": return "-..";    "E": return ".";      "F": return "..-.";
            "G": return "--.";    "H": return "....";   "I": return "..";
            "J": return ".---";   "K": return "-.-";    "L": return ".-..";
            "M": return "--";     "N": return "-.";     "O": return "---";
            "P": return ".--.";   "Q": return "--.-";   "R": return ".-.";
            "S": return "...";    "T": return "-";      "U": return "..-";
            "V": return "...-";   "W": return ".--";    "X": return "-..-";
            "Y": return "-.--";   "Z": return "--..";
            "0": return "-----";  "1": return ".----";  "2": return "..---";
            "3": return "...--";  "4": return "....-";  "5": return ".....";
            "6": return "-....";  "7": return "--...";  "8": return "---..";
            "9": return "----.";
            ".": return ".-.-.-"; ",": return "--..--"; ":": return "---...";
            "?": return "..--.."; "'": return ".----."; "-": return "-....-";
            "/": return "-..-.";  "(": return "-.--.";  ")": return "-.--.-";
            "\"": return ".-..-."; "=": return "-...-"; "+": return ".-.-.";
            "@": return ".--.-.";
            default: return "";
        endcase
    endfunction

    function void add_unit(logic key, logic bad);
        keying_unit_t u;
        u.key_on    = key;
        u.bad_char  = bad;
        u.last_unit = 1'b0;
        units_due.push_back(u);
    endfunction

    // work out the units an accepted character gives and queue them
    function void note_char(logic [7:0] code, logic eom);
        string        pat;
        keying_unit_t tail;
        if (code == mku_pkg::CHAR_SPACE) begin
            // owed gap dropped, word gap of six off units
            gap_owed = 1'b0;
            repeat (6) add_unit(1'b0, 1'b0);
        end
        else begin
            pat = morse_pattern(code);
            if (pat.len() == 0) begin
                // unknown code: one flagged unit, gap kept unless message ends
                add_unit(1'b0, 1'b1);
                if (eom)
                    gap_owed = 1'b0;
            end
            else begin
                if (gap_owed)
                    repeat (2) add_unit(1'b0, 1'b0);
                for (int k = 0; k < pat.len(); k++) begin
                    if (pat[k] == "-")
                        repeat (3) add_unit(1'b1, 1'b0);
                    else
                        add_unit(1'b1, 1'b0);
                    add_unit(1'b0, 1'b0);
                end
                // end of message flushes the letter gap at once
                if (eom) begin
                    repeat (2) add_unit(1'b0, 1'b0);
                    gap_owed = 1'b0;
                end
                else begin
                    gap_owed = 1'b1;
                end
            end
        end
        tail = units_due.pop_back();
        tail.last_unit = 1'b1;
        units_due.push_back(tail);
    endfunction

    // compare one output transfer with the oldest unit due
    function void check_unit(logic key, logic bad, logic last);
        keying_unit_t want;
        if (units_due.size() == 0) begin
            $error("keying unit with nothing due: key_on=%0b bad_char=%0b last_unit=%0b",
                   key, bad, last);
            errors++;
            return;
        end
        want = units_due.pop_front();
        if (key !== want.key_on) begin
            $error("key_on: expected %0b, got %0b", want.key_on, key);
            errors++;
        end
        if (bad !== want.bad_char) begin
            $error("bad_char: expected %0b, got %0b", want.bad_char, bad);
            errors++;
        end
        if (last !== want.last_unit) begin
            $error("last_unit: expected %0b, got %0b", want.last_unit, last);
            errors++;
        end
    endfunction
endclass

module testbench;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 76;
    localparam int DRAIN_CYCLES = 30;
    localparam string KNOWN_CHARS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789.,:?'-/()\"=+@";

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic       in_ready;
    logic [7:0] char_code      = 8'h00;
    logic       end_of_message = 1'b0;
    logic       out_valid;
    logic       out_ready      = 1'b0;
    logic       key_on;
    logic       bad_char;
    logic       last_unit;

    keying_scoreboard sb = new;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int quiet_cycles   = 0;

    morse_keying_unit_encoder_unit u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .char_code      (char_code),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .key_on         (key_on),
        .bad_char       (bad_char),
        .last_unit      (last_unit)
    );

    // clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // receiver stalls
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // output checking and watchdog on transfers
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready)
                sb.check_unit(key_on, bad_char, last_unit);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // one character transfer, entered and left at a falling edge
    task automatic send_char(input logic [7:0] code, input logic eom);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid       <= 1'b1;
        char_code      <= code;
        end_of_message <= eom;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_char(code, eom);
        chars_sent++;
        @(negedge clk);
    endtask

    // a message of random content; some are broken with stray or missing ends
    task automatic send_message();
        int         msg_len;
        int         pick;
        logic       broken;
        logic       eom;
        logic [7:0] code;
        msg_len = $urandom_range(1, 10);
        broken  = ($urandom_range(0, 9) == 0);
        for (int i = 0; i < msg_len; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                code = KNOWN_CHARS[$urandom_range(0, KNOWN_CHARS.len() - 1)];
            end
            else if (pick < 84) begin
                code = mku_pkg::CHAR_SPACE;
            end
            else begin
                do
                    code = 8'($urandom_range(0, 255));
                while (sb.morse_pattern(code) != "" || code == mku_pkg::CHAR_SPACE);
            end
            if (broken)
                eom = ($urandom_range(0, 3) == 0);
            else
                eom = (i == msg_len - 1);
            send_char(code, eom);
        end
    endtask

    // stimulus and end of run
    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: extremes, gap handling, unknown codes, spaces
        send_idle_pct  = 17;
        recv_stall_pct = 51;
        send_char("E", 1'b0);
        send_char("T", 1'b0);
        send_char(" ", 1'b0);
        send_char(" ", 1'b0);
        send_char("0", 1'b0);
        send_char(",", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("A", 1'b0);
        send_char(8'hFF, 1'b1);
        send_char("5", 1'b0);
        send_char(" ", 1'b1);
        send_char("@", 1'b1);
        send_char(".", 1'b0);
        send_char(8'h61, 1'b0);
        send_char(8'h80, 1'b0);
        send_char("\"", 1'b0);
        send_char("'", 1'b0);
        send_char("?", 1'b0);
        send_char("-", 1'b0);
        send_char(":", 1'b0);
        send_char("(", 1'b0);
        send_char(")", 1'b0);
        send_char("/", 1'b0);
        send_char("=", 1'b0);
        send_char("+", 1'b1);

        // random messages under three idling profiles
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 17; recv_stall_pct = 51; end
                1: begin send_idle_pct = 51; recv_stall_pct = 17; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            while (chars_sent < 25 + (phase + 1) * PHASE_ITEMS)
                send_message();
        end
        in_valid <= 1'b0;

        // drain, then allow for any stray units
        while (sb.units_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
